@@ rtl/mrcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrcc_pkg
// Types, codes and format helpers shared by the min-max rescale / clamp
// converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrcc_pkg;

  localparam int unsigned VAL_W      = 33;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned CNT_W      = $clog2(QUOT_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;

  typedef logic signed [VAL_W-1:0] val_t;

  // sample format codes
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_FMT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FMT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_MAX = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_FLAT = 2'd2;

  localparam logic MODE_CLAMP = 1'b0;

  localparam val_t DMIN_RESET = 33'sh0_FFFF_FFFF;
  localparam val_t DMAX_RESET = 33'sh1_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMITS,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [2:0] in_fmt;
    logic [2:0] out_fmt;
    val_t       conv_min;
    val_t       conv_max;
  } cfg_t;

  typedef struct packed {
    logic scan;
    logic latch;
    logic limits;
    logic eval;
    logic mul;
    logic div;
    logic fin;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic val_t decode(input logic [2:0] fmt, input logic [SAMPLE_W-1:0] raw);
    val_t r;
    case (fmt)
      FMT_S8:  r = {{25{raw[7]}}, raw[7:0]};
      FMT_U8:  r = {25'd0, raw[7:0]};
      FMT_S16: r = {{17{raw[15]}}, raw[15:0]};
      FMT_U16: r = {17'd0, raw[15:0]};
      FMT_S32: r = {raw[31], raw};
      default: r = {1'b0, raw};
    endcase
    return r;
  endfunction

  function automatic val_t fmt_lo(input logic [2:0] fmt);
    val_t r;
    case (fmt)
      FMT_S8:  r = -33'sd128;
      FMT_S16: r = -33'sd32768;
      FMT_S32: r = -33'sd2147483648;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  function automatic val_t fmt_hi(input logic [2:0] fmt);
    val_t r;
    case (fmt)
      FMT_S8:  r = 33'sd127;
      FMT_U8:  r = 33'sd255;
      FMT_S16: r = 33'sd32767;
      FMT_U16: r = 33'sd65535;
      FMT_S32: r = 33'sd2147483647;
      default: r = 33'sd4294967295;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mrcc_in_if.sv @@
// ----------------------------------------------------------------------------
// mrcc_in_if
// Request channel: valid/ready handshake with scan or convert sample payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrcc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        first_of_set;
  logic [31:0] sample;

  modport source (output valid, req_type, first_of_set, sample, input ready);
  modport sink   (input valid, req_type, first_of_set, sample, output ready);
endinterface

`default_nettype wire

@@ rtl/mrcc_out_if.sv @@
// ----------------------------------------------------------------------------
// mrcc_out_if
// Result channel: valid/ready handshake with converted value and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

@@ rtl/mrcc_cfg.sv @@
// ----------------------------------------------------------------------------
// mrcc_cfg
// Configuration register file, written by index through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrcc_cfg
  import mrcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_CLAMP;
      cfg_q.in_fmt   <= FMT_U8;
      cfg_q.out_fmt  <= FMT_U8;
      cfg_q.conv_min <= 33'sd0;
      cfg_q.conv_max <= 33'sd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:     cfg_q.mode     <= cfg_data_i[0];
        CFG_IN_FMT:   cfg_q.in_fmt   <= cfg_data_i[2:0];
        CFG_OUT_FMT:  cfg_q.out_fmt  <= cfg_data_i[2:0];
        CFG_CONV_MIN: cfg_q.conv_min <= cfg_data_i;
        CFG_CONV_MAX: cfg_q.conv_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/mrcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrcc_ctrl
// Sequencer: accepts requests, steps the datapath through limits, evaluation,
// multiply, bit-serial divide and result write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module mrcc_ctrl
  import mrcc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_req_type_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && in_req_type_i) state_d = ST_LIMITS;
      ST_LIMITS: state_d = ST_EVAL;
      ST_EVAL:   state_d = sts_i.direct ? ST_LOAD : ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN:    state_d = ST_LOAD;
      ST_LOAD:   if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.scan   = in_valid_i && !in_req_type_i;
        cmd_o.latch  = in_valid_i && in_req_type_i;
      end
      ST_LIMITS: cmd_o.limits = 1'b1;
      ST_EVAL:   cmd_o.eval   = 1'b1;
      ST_MUL:    cmd_o.mul    = 1'b1;
      ST_DIV:    cmd_o.div    = 1'b1;
      ST_FIN:    cmd_o.fin    = 1'b1;
      ST_LOAD:   cmd_o.load   = sts_i.out_free;
      default: ;
    endcase
  end

  a_convert_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_type_i) |=> (state_q == ST_LIMITS))
    else $error("convert request did not start the sequence");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result loaded over a pending result");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_done) |=> (state_q == ST_DIV))
    else $error("divide left before last quotient bit");

endmodule

`default_nettype wire

@@ rtl/mrcc_dp.sv @@
// ----------------------------------------------------------------------------
// mrcc_dp
// Datapath: set extremes, limit saturation, clamp and rescale arithmetic with
// a radix-2 restoring divider, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrcc_dp
  import mrcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  input  logic                in_first_i,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  input  logic                out_ready_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  output val_t                out_value_o,
  output logic [1:0]          out_status_o
);

  // set tracking
  val_t dmin_q, dmax_q;
  logic seen_q;

  // item operands
  val_t              x_q, lo_q, hi_q;
  logic [VAL_W-1:0]  den_q, t_q;
  logic [QUOT_W-1:0] aspan_q;
  logic              neg_q;

  // divider
  logic [VAL_W-1:0]  rem_q;
  logic [QUOT_W-1:0] sh_q;
  logic [CNT_W-1:0]  cnt_q;

  // result and output register
  val_t       res_v_q, out_v_q;
  logic [1:0] res_st_q, out_st_q;
  logic       out_valid_q;

  val_t              x_in, flo, fhi, lo_c, hi_c, xs, v_direct;
  logic [1:0]        st_direct;
  logic              flat, clip;
  logic [VAL_W:0]    t_w, den_w, span_w, aspan_w;
  logic [2*QUOT_W:0] prod;
  logic [VAL_W:0]    r2, r2_sub;
  logic              ge;
  logic [VAL_W:0]    fin_w, q_ext;

  assign x_in = decode(cfg_i.in_fmt, in_sample_i);
  assign flo  = fmt_lo(cfg_i.out_fmt);
  assign fhi  = fmt_hi(cfg_i.out_fmt);

  always_comb begin
    if (cfg_i.conv_min < flo)      lo_c = flo;
    else if (cfg_i.conv_min > fhi) lo_c = fhi;
    else                           lo_c = cfg_i.conv_min;
    if (cfg_i.conv_max < flo)      hi_c = flo;
    else if (cfg_i.conv_max > fhi) hi_c = fhi;
    else                           hi_c = cfg_i.conv_max;
  end

  assign flat = !seen_q || (dmax_q <= dmin_q);

  always_comb begin
    st_direct = STAT_OK;
    v_direct  = x_q;
    if (cfg_i.mode == MODE_CLAMP) begin
      if (x_q < lo_q) begin
        v_direct  = lo_q;
        st_direct = STAT_SAT;
      end else if (x_q > hi_q) begin
        v_direct  = hi_q;
        st_direct = STAT_SAT;
      end
    end else begin
      v_direct  = lo_q;
      st_direct = STAT_FLAT;
    end
  end

  // sample pulled into the set range
  always_comb begin
    clip = 1'b1;
    if (x_q < dmin_q)      xs = dmin_q;
    else if (x_q > dmax_q) xs = dmax_q;
    else begin
      xs   = x_q;
      clip = 1'b0;
    end
  end

  assign t_w     = {xs[VAL_W-1], xs} - {dmin_q[VAL_W-1], dmin_q};
  assign den_w   = {dmax_q[VAL_W-1], dmax_q} - {dmin_q[VAL_W-1], dmin_q};
  assign span_w  = {hi_q[VAL_W-1], hi_q} - {lo_q[VAL_W-1], lo_q};
  assign aspan_w = span_w[VAL_W] ? (~span_w + 1'b1) : span_w;

  assign prod = aspan_q * t_q;

  // one restoring step, remainder stays below the divisor
  assign r2     = {rem_q, sh_q[QUOT_W-1]};
  assign ge     = r2 >= {1'b0, den_q};
  assign r2_sub = r2 - {1'b0, den_q};

  assign q_ext = {{(VAL_W-QUOT_W+1){1'b0}}, sh_q};
  assign fin_w = neg_q ? ({lo_q[VAL_W-1], lo_q} - q_ext) : ({lo_q[VAL_W-1], lo_q} + q_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q      <= DMIN_RESET;
      dmax_q      <= DMAX_RESET;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan) begin
        seen_q <= 1'b1;
        if (in_first_i) begin
          dmin_q <= x_in;
          dmax_q <= x_in;
        end else begin
          if (x_in < dmin_q) dmin_q <= x_in;
          if (x_in > dmax_q) dmax_q <= x_in;
        end
      end
      if (cmd_i.mul)      cnt_q <= '0;
      else if (cmd_i.div) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.load)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) x_q <= x_in;
    if (cmd_i.limits) begin
      lo_q <= lo_c;
      hi_q <= hi_c;
    end
    if (cmd_i.eval) begin
      t_q      <= t_w[VAL_W-1:0];
      den_q    <= den_w[VAL_W-1:0];
      aspan_q  <= aspan_w[QUOT_W-1:0];
      neg_q    <= span_w[VAL_W];
      res_v_q  <= v_direct;
      res_st_q <= (sts_o.direct) ? st_direct : (clip ? STAT_SAT : STAT_OK);
    end
    if (cmd_i.mul) begin
      rem_q <= prod[2*QUOT_W:QUOT_W];
      sh_q  <= prod[QUOT_W-1:0];
    end
    if (cmd_i.div) begin
      rem_q <= ge ? r2_sub[VAL_W-1:0] : r2[VAL_W-1:0];
      sh_q  <= {sh_q[QUOT_W-2:0], ge};
    end
    if (cmd_i.fin) res_v_q <= fin_w[VAL_W-1:0];
    if (cmd_i.load) begin
      out_v_q  <= res_v_q;
      out_st_q <= res_st_q;
    end
  end

  assign sts_o.direct   = (cfg_i.mode == MODE_CLAMP) || flat;
  assign sts_o.div_done = (cnt_q == CNT_W'(QUOT_W - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_v_q;
  assign out_status_o = out_st_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul || cmd_i.div) |=> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_scan_orders_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> (seen_q && (dmin_q <= dmax_q)))
    else $error("set extremes out of order after scan");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ rtl/minmax_rescale_clamp_convert_top.sv @@
// ----------------------------------------------------------------------------
// minmax_rescale_clamp_convert_top
// Integer sample format converter with clamp or min-max rescale to limits.
// ----------------------------------------------------------------------------
// A scan request folds its sample into the set minimum and maximum at the
// edge that accepts it and gives no result. A convert request gives one
// result: in clamp mode, or for an empty or flat set, the request steps
// through the limit and evaluation states to write-back; a rescale also
// passes through a single 32x33 multiply, the radix-2 restoring divider that
// produces one of 32 quotient bits per cycle, and a final offset add before
// write-back. One request is worked on at a time; a finished result waits in
// the output register while the next request is accepted, and a convert only
// stalls at write-back if that register is still full.
`default_nettype none

module minmax_rescale_clamp_convert_top
  import mrcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mrcc_in_if.sink               in_if,
  mrcc_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       in_ready;
  logic       out_valid;
  val_t       out_value;
  logic [1:0] out_status;

  mrcc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mrcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_req_type_i (in_if.req_type),
    .in_ready_o    (in_ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mrcc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .in_first_i   (in_if.first_of_set),
    .in_sample_i  (in_if.sample),
    .out_ready_i  (out_if.ready),
    .sts_o        (sts),
    .out_valid_o  (out_valid),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign in_if.ready   = in_ready;
  assign out_if.valid  = out_valid;
  assign out_if.value  = out_value;
  assign out_if.status = out_status;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-max rescale / clamp format converter:
// directed corner requests, then random scan/convert sets over many register
// settings, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mrcc_pkg::*;

  localparam logic REQ_SCAN     = 1'b0;
  localparam logic REQ_CONVERT  = 1'b1;
  localparam logic MODE_RESCALE = 1'b1;

  localparam int DRAIN_CYCLES   = 45;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_REQUESTS = 75;
  localparam int HOLD_OFF       = 400;

  class conversion_scoreboard;
    typedef struct {
      logic signed [32:0] value;
      logic [1:0]         status;
    } conversion_t;

    logic        mode;
    logic [2:0]  src_fmt;
    logic [2:0]  dst_fmt;
    longint      lim_min;
    longint      lim_max;
    longint      set_min;
    longint      set_max;
    bit          set_seen;
    conversion_t pending_conversions[$];
    int          errors;

    function new();
      mode     = MODE_CLAMP;
      src_fmt  = FMT_U8;
      dst_fmt  = FMT_U8;
      lim_min  = 0;
      lim_max  = 255;
      set_min  = 64'sd4294967295;
      set_max  = -64'sd4294967296;
      set_seen = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return pending_conversions.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    function void write_reg(input logic [2:0] idx, input logic [32:0] data);
      logic signed [32:0] sdata;
      sdata = data;
      case (idx)
        CFG_MODE:     mode = data[0];
        CFG_IN_FMT:   src_fmt = data[2:0];
        CFG_OUT_FMT:  dst_fmt = data[2:0];
        CFG_CONV_MIN: lim_min = sdata;
        CFG_CONV_MAX: lim_max = sdata;
        default: ;
      endcase
    endfunction

    function longint sample_value(input logic [2:0] fmt, input logic [31:0] raw);
      case (fmt)
        FMT_S8:  return {{56{raw[7]}}, raw[7:0]};
        FMT_U8:  return {56'd0, raw[7:0]};
        FMT_S16: return {{48{raw[15]}}, raw[15:0]};
        FMT_U16: return {48'd0, raw[15:0]};
        FMT_S32: return {{32{raw[31]}}, raw};
        default: return {32'd0, raw};
      endcase
    endfunction

    function void format_bounds(input logic [2:0] fmt, output longint lo, output longint hi);
      case (fmt)
        FMT_S8:  begin lo = -128;          hi = 127;           end
        FMT_U8:  begin lo = 0;             hi = 255;           end
        FMT_S16: begin lo = -32768;        hi = 32767;         end
        FMT_U16: begin lo = 0;             hi = 65535;         end
        FMT_S32: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
        default: begin lo = 0;             hi = 64'sd4294967295; end
      endcase
    endfunction

    function longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // fold a scan into the set extremes, or queue the expected conversion
    function void note_request(input logic req_type, input logic first,
                               input logic [31:0] raw);
      longint       x, flo, fhi, lo, hi, v, xs, span, q;
      logic [127:0] num, offs, den, quo;
      logic [1:0]   st;
      conversion_t  r;
      x = sample_value(src_fmt, raw);
      if (req_type == REQ_SCAN) begin
        if (first) begin
          set_min = x;
          set_max = x;
        end else begin
          if (x < set_min) set_min = x;
          if (x > set_max) set_max = x;
        end
        set_seen = 1'b1;
        return;
      end
      format_bounds(dst_fmt, flo, fhi);
      lo = clip(lim_min, flo, fhi);
      hi = clip(lim_max, flo, fhi);
      st = STAT_OK;
      if (mode == MODE_CLAMP) begin
        // crossed limits: a sample below the lower limit gets it, any other the upper
        if (x < lo) begin
          v  = lo;
          st = STAT_SAT;
        end else if (x > hi) begin
          v  = hi;
          st = STAT_SAT;
        end else begin
          v = x;
        end
      end else if (!set_seen || set_max <= set_min) begin
        v  = lo;
        st = STAT_FLAT;
      end else begin
        xs = clip(x, set_min, set_max);
        if (xs != x) st = STAT_SAT;
        span = hi - lo;
        num  = (span < 0) ? -span : span;
        offs = xs - set_min;
        den  = set_max - set_min;
        quo  = (num * offs) / den;
        q    = quo[63:0];
        v    = (span < 0) ? lo - q : lo + q;
      end
      r.value  = v[32:0];
      r.status = st;
      pending_conversions.push_back(r);
    endfunction

    task check_result(input logic signed [32:0] value, input logic [1:0] status);
      conversion_t e;
      if (pending_conversions.size() == 0) begin
        report($sformatf("unexpected result value %0d status %0d", value, status));
        return;
      end
      e = pending_conversions.pop_front();
      if (value !== e.value)
        report($sformatf("value %0d, expected %0d", value, e.value));
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d (value %0d)", status, e.status, e.value));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_idx;
  logic [32:0]       cfg_data;
  bit                idle_on;
  int                hold_cycles;

  conversion_scoreboard sb = new();

  mrcc_in_if  req_if ();
  mrcc_out_if res_if ();

  minmax_rescale_clamp_convert_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (req_if),
    .out_if     (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.req_type, req_if.first_of_set, req_if.sample);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.value, res_if.status);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send(input logic rt, input logic first, input logic [31:0] raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rt;
    req_if.first_of_set <= first;
    req_if.sample       <= raw;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  // scans give no result, so allow the block time to settle after the last one
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [32:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic m, input logic [2:0] src, input logic [2:0] dst,
                           input logic [32:0] cmin, input logic [32:0] cmax);
    wait_drained();
    write_reg(CFG_MODE, {32'd0, m});
    write_reg(CFG_IN_FMT, {30'd0, src});
    write_reg(CFG_OUT_FMT, {30'd0, dst});
    write_reg(CFG_CONV_MIN, cmin);
    write_reg(CFG_CONV_MAX, cmax);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [2:0] pick_format();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(0, 5));
  endfunction

  function automatic logic [32:0] pick_limit();
    longint tmp;
    case ($urandom_range(0, 4))
      0: tmp = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom()};
      1: tmp = longint'($urandom_range(0, 600)) - 300;
      2: tmp = $urandom_range(0, 70000);
      3: begin
        case ($urandom_range(0, 8))
          0: tmp = 0;
          1: tmp = 255;
          2: tmp = 127;
          3: tmp = -128;
          4: tmp = 65535;
          5: tmp = -64'sd2147483648;
          6: tmp = 64'sd2147483647;
          7: tmp = 64'sd4294967295;
          default: tmp = -64'sd4294967296;
        endcase
      end
      default: tmp = {{32{1'b0}}, $urandom()} - 64'sd2147483648;
    endcase
    return tmp[32:0];
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return ($urandom() & ~32'hFF) | 32'($urandom_range(120, 135));
      2: begin
        case ($urandom_range(0, 7))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          4: return 32'h0000_8000;
          5: return 32'h0000_7FFF;
          6: return 32'h0000_0080;
          default: return 32'h0000_007F;
        endcase
      end
      3: return 32'($urandom_range(0, 65535));
      default: return $urandom();
    endcase
  endfunction

  task automatic directed_requests();
    // reset settings: clamp u8 to u8 within 0..255, upper sample bits ignored
    send(REQ_CONVERT, 1'b0, 32'h0000_0080);
    send(REQ_CONVERT, 1'b0, 32'hFFFF_FF00);
    configure(MODE_RESCALE, FMT_U8, FMT_U8, 33'd0, 33'd255);
    send(REQ_CONVERT, 1'b0, 32'h10);      // nothing scanned since reset
    send(REQ_SCAN,    1'b0, 32'h40);      // fresh set without first flag
    send(REQ_CONVERT, 1'b0, 32'h40);      // flat set
    send(REQ_SCAN,    1'b0, 32'hC0);
    send(REQ_CONVERT, 1'b0, 32'h80);
    send(REQ_CONVERT, 1'b0, 32'h00);      // below the set
    send(REQ_CONVERT, 1'b0, 32'hFF);      // above the set
    // source format change keeps the set, limits crossed
    configure(MODE_RESCALE, FMT_S8, FMT_U8, 33'd200, 33'd10);
    send(REQ_CONVERT, 1'b0, 32'h50);
    send(REQ_CONVERT, 1'b0, 32'h80);
    // limits beyond the destination range
    configure(MODE_RESCALE, FMT_S32, FMT_S8, -33'sd1000, 33'sd1000);
    send(REQ_SCAN,    1'b1, 32'h8000_0000);
    send(REQ_SCAN,    1'b0, 32'h7FFF_FFFF);
    send(REQ_CONVERT, 1'b0, 32'h0000_0000);
    send(REQ_CONVERT, 1'b0, 32'hFFFF_FFFF);
    // widest span and widest set
    configure(MODE_RESCALE, FMT_U32, FMT_U32, 33'd0, 33'h0_FFFF_FFFF);
    send(REQ_SCAN,    1'b0, 32'hFFFF_FFFF);
    send(REQ_CONVERT, 1'b0, 32'hFFFF_FFFE);
    send(REQ_CONVERT, 1'b0, 32'h0000_0000);
    configure(MODE_CLAMP, FMT_U8, FMT_U8, 33'd100, 33'd50);
    send(REQ_CONVERT, 1'b0, 32'd30);
    send(REQ_CONVERT, 1'b0, 32'd70);
    send(REQ_CONVERT, 1'b0, 32'd200);
    // unused format codes behave as u32
    configure(MODE_CLAMP, 3'd7, 3'd6, 33'h1_0000_0000, 33'h0_FFFF_FFFF);
    send(REQ_CONVERT, 1'b0, 32'hFFFF_FFFF);
    send(REQ_CONVERT, 1'b0, 32'h8000_0000);
  endtask

  task automatic random_phase(input int phase);
    logic [32:0] cmin, cmax, swap;
    logic [31:0] v;
    int          sent;
    int          n;
    cmin = pick_limit();
    cmax = pick_limit();
    if ($urandom_range(0, 3) != 0 && $signed(cmin) > $signed(cmax)) begin
      swap = cmin;
      cmin = cmax;
      cmax = swap;
    end
    configure(1'($urandom_range(0, 1)), pick_format(), pick_format(), cmin, cmax);
    idle_on = (phase < NUM_PHASES - 3) && (phase % 4 != 2);
    if (phase == 3) hold_cycles = HOLD_OFF;
    sent = 0;
    while (sent < PHASE_REQUESTS) begin
      case ($urandom_range(0, 9))
        7: begin
          n = $urandom_range(1, 3);
          repeat (n) send(REQ_CONVERT, 1'($urandom_range(0, 1)), pick_sample());
          sent += n;
        end
        8: begin
          n = $urandom_range(1, 3);
          repeat (n) send(REQ_SCAN, 1'b0, pick_sample());
          sent += n;
        end
        9: begin
          // one-value set
          v = pick_sample();
          send(REQ_SCAN, 1'b1, v);
          send(REQ_SCAN, 1'b0, v);
          send(REQ_CONVERT, 1'b0, pick_sample());
          sent += 3;
        end
        default: begin
          send(REQ_SCAN, 1'b1, pick_sample());
          n = $urandom_range(0, 6);
          repeat (n) send(REQ_SCAN, 1'b0, pick_sample());
          sent += n + 1;
          n = $urandom_range(1, 5);
          repeat (n) send(REQ_CONVERT, 1'b0, pick_sample());
          sent += n;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int guard;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_MODE;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_SCAN;
    req_if.first_of_set = 1'b0;
    req_if.sample       = '0;
    res_if.ready        = 1'b0;
    idle_on             = 1'b1;
    hold_cycles         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();
    for (int p = 0; p < NUM_PHASES; p++) random_phase(p);

    req_if.valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d conversions never came out", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mrcc_pkg.sv
rtl/mrcc_in_if.sv
rtl/mrcc_out_if.sv
rtl/mrcc_cfg.sv
rtl/mrcc_ctrl.sv
rtl/mrcc_dp.sv
rtl/minmax_rescale_clamp_convert_top.sv
tb/sv/tb_top.sv
